// ===== design/sha256_byte_stream_hasher_top_assert.svh =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top_assert
// Assertion macros shared by the hasher RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_ADD, ST_OUT
  } state_e;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef logic [31:0] word_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ===== design/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// One SHA-256 round per cycle over a 16-word schedule window; then adds the working
// words back into the eight chaining words in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic [511:0] block_i,
  input  wire logic        init_i,
  output logic             done_o,
  output sha_pkg::word_t   hash_o [8]
);
  `include "sha256_byte_stream_hasher_top_assert.svh"

  sha_pkg::word_t h_q [8];
  sha_pkg::word_t h_d [8];
  sha_pkg::word_t v_q [8];
  sha_pkg::word_t v_d [8];
  sha_pkg::word_t w_q [16];
  sha_pkg::word_t w_d [16];
  logic [6:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  sha_pkg::word_t t1, t2, s0, s1, wn, sum;

  always_comb begin
    h_d = h_q; v_d = v_q; w_d = w_q;
    cnt_d = cnt_q; busy_d = busy_q; done_o = 1'b0;
    s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
         ^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + sha_pkg::ROUND_K[cnt_q[5:0]] + w_q[0];
    t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
         ^ sha_pkg::rotr(v_q[0], 22)) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
         ^ (v_q[1] & v_q[2]));
    sum = h_q[cnt_q[2:0]] + v_q[cnt_q[2:0]];
    if (init_i) begin
      for (int i = 0; i < 8; i++) h_d[i] = sha_pkg::INIT_HASH[i];
    end else if (load_i) begin
      for (int i = 0; i < 16; i++) w_d[i] = block_i[511 - 32*i -: 32];
      v_d = h_q; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!cnt_q[6]) begin
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wn;
        for (int i = 7; i > 0; i--) v_d[i] = v_q[i-1];
        v_d[4] = v_q[3] + t1;
        v_d[0] = t1 + t2;
        cnt_d = cnt_q + 7'd1;
      end else begin
        h_d[cnt_q[2:0]] = sum;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[2:0] == 3'd7) begin
          busy_d = 1'b0; done_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_HASH[i];
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; w_q <= w_d;
  end

  assign hash_o = h_q;

  `SHA_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_q)
  `SHA_ASSERT_NXT(a_load_busy, clk_i, rst_ni, load_i && !init_i, busy_q)
  `SHA_ASSERT_IMP(a_no_load_busy, clk_i, rst_ni, busy_q, !load_i)
endmodule
`default_nettype wire

// ===== design/sha256_byte_stream_hasher_top.sv =====
// A byte that fills a block starts a compression of 64 rounds plus 8 chain
// additions in the shared round unit. A finish runs the padding and one or two
// compressions, then puts out 8 digest words. Input bytes are held off while
// the round unit compresses a block.
// Reset (asynchronous, active low) loads the initial hash and empties the count.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// Byte stream SHA-256 hasher: block fill, padding, compression and digest out.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_byte_stream_hasher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  wire logic        s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_index[34:32], 0
  output logic             m_axis_tlast    // last_word
);
  `include "sha256_byte_stream_hasher_top_assert.svh"

  sha_pkg::state_e state_q, state_d;
  logic [511:0] buf_q, buf_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  len_q, len_d;
  logic [2:0]   idx_q, idx_d;
  logic         fin_q, fin_d;
  logic         load, init, done;
  logic [7:0]   wbyte;
  logic         wr;
  logic [63:0]  bits;
  sha_pkg::word_t hash [8];

  assign bits = {len_q, 3'b000};

  always_comb begin
    state_d = state_q; fill_d = fill_q; len_d = len_q; idx_d = idx_q;
    fin_d = fin_q; load = 1'b0; init = 1'b0; wr = 1'b0; wbyte = '0;
    s_axis_tready = 1'b0; m_axis_tvalid = 1'b0;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            wr = 1'b1; wbyte = sha_pkg::PAD_MARKER; fin_d = 1'b1;
            state_d = sha_pkg::ST_PAD;
          end else begin
            wr = 1'b1; wbyte = s_axis_tdata; len_d = len_q + 61'd1;
          end
          if (fill_q == 6'd63) begin
            load = 1'b1; state_d = sha_pkg::ST_ROUND;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        if (fill_q == sha_pkg::LEN_START) begin
          idx_d = 3'd7; state_d = sha_pkg::ST_LEN;
        end else begin
          wr = 1'b1;
          if (fill_q == 6'd63) begin
            load = 1'b1; state_d = sha_pkg::ST_ROUND;
          end
        end
      end
      sha_pkg::ST_LEN: begin
        wr = 1'b1; wbyte = bits[{idx_q, 3'b000} +: 8]; idx_d = idx_q - 3'd1;
        if (fill_q == 6'd63) begin
          load = 1'b1; state_d = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        if (done) begin
          if (!fin_q) state_d = sha_pkg::ST_IDLE;
          else if (idx_q == 3'd7 && fill_q == 6'd0) state_d = sha_pkg::ST_OUT;
          else state_d = sha_pkg::ST_PAD;
          idx_d = '0;
        end
      end
      sha_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            init = 1'b1; fin_d = 1'b0; len_d = '0; state_d = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
    if (wr) fill_d = fill_q + 6'd1;
  end

  // idx_q is 7 after the length bytes wrap; mark that for the final block
  logic len_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) len_done_q <= 1'b0;
    else if (state_q == sha_pkg::ST_LEN && load) len_done_q <= 1'b1;
    else if (init) len_done_q <= 1'b0;
  end

  always_comb begin
    buf_d = buf_q;
    if (wr) buf_d[511 - {fill_q, 3'b000} -: 8] = wbyte;
  end

  logic [2:0] idx_n;
  assign idx_n = (state_q == sha_pkg::ST_ROUND && done && len_done_q) ? 3'd0 : idx_d;

  logic to_out;
  assign to_out = state_q == sha_pkg::ST_ROUND && done && len_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE; fill_q <= '0; len_q <= '0; idx_q <= '0;
      fin_q <= 1'b0;
    end else begin
      state_q <= to_out ? sha_pkg::ST_OUT
               : (state_q == sha_pkg::ST_ROUND && done && fin_q)
               ? sha_pkg::ST_PAD : state_d;
      fill_q <= fill_d; len_q <= len_d; idx_q <= idx_n; fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  sha_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .block_i(buf_d),
    .init_i (init),
    .done_o (done),
    .hash_o (hash)
  );

  assign m_axis_tdata = {5'd0, idx_q, hash[idx_q]};
  assign m_axis_tlast = idx_q == 3'd7;

  `SHA_ASSERT_IMP(a_out_only, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `SHA_ASSERT_IMP(a_out_fill, clk_i, rst_ni, m_axis_tvalid, fill_q == 6'd0)
  `SHA_ASSERT_NXT(a_last_idle, clk_i, rst_ni,
                  m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams message bytes and finish requests into the SHA-256 byte stream
// hasher and checks each digest word against a built-in SHA-256 predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       fin;
    logic [7:0] byte_v;
  } req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  req_t        pending_q[$];
  digest_t     digest_q[$];
  int          hold_q[$];
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [60:0] msg_len;
  int unsigned gap_cnt;
  int unsigned rx_wait;
  int unsigned idle_cycles;
  int unsigned fail_cnt;
  bit          feed_done;

  sha256_byte_stream_hasher_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    chain = sha_pkg::INIT_HASH;
    fill = 0;
    msg_len = '0;
  endtask

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      w[t] = w[t-16] + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain[i] += v[i];
    end
  endtask

  task automatic absorb(logic [7:0] b);
    blk[fill] = b;
    fill = (fill + 1) % 64;
    if (fill == 0) begin
      compress();
    end
  endtask

  // advance the hash state for one accepted request, queue any digest words
  task automatic predict_digest(req_t r);
    logic [63:0] bits;
    if (!r.fin) begin
      absorb(r.byte_v);
      msg_len = msg_len + 1'b1;
    end else begin
      bits = {msg_len, 3'b000};
      absorb(sha_pkg::PAD_MARKER);
      while (fill != sha_pkg::LEN_START) begin
        absorb(8'h00);
      end
      for (int i = 7; i >= 0; i--) begin
        absorb(bits[8*i +: 8]);
      end
      for (int i = 0; i < 8; i++) begin
        digest_q.push_back('{chain[i], 3'(i), i == 7});
      end
      hash_reset();
    end
  endtask

  task automatic add_msg(int n, int mode);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r.fin = 1'b0;
      case (mode)
        0: r.byte_v = 8'(i);
        1: r.byte_v = 8'hff;
        default: r.byte_v = 8'($urandom);
      endcase
      pending_q.push_back(r);
      hold_q.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0);
    end
    r.fin = 1'b1;
    r.byte_v = 8'($urandom);
    pending_q.push_back(r);
    hold_q.push_back($urandom_range(0, 19));
  endtask

  initial begin
    int total;
    int n;
    hash_reset();
    add_msg(0, 0);
    add_msg(3, 1);
    add_msg(9, 0);
    // flag a pause until all digests drain
    hold_q[hold_q.size() - 1] = -1;
    total = 15;
    while (total < 430) begin
      case ($urandom_range(0, 5))
        0: n = $urandom_range(54, 58);
        1: n = $urandom_range(62, 66);
        2: n = $urandom_range(110, 130);
        default: n = $urandom_range(0, 20);
      endcase
      if (total + n + 1 > 430) n = 430 - total - 1;
      add_msg(n, 2);
      total += n + 1;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digest('{s_axis_tuser, s_axis_tdata});
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          feed_done <= 1'b1;
        end else if (hold_q[0] < 0) begin
          s_axis_tvalid <= 1'b0;
          if (digest_q.size() == 0 && !(s_axis_tvalid && s_axis_tready)) begin
            hold_q[0] = 0;
          end
        end else if (gap_cnt < hold_q[0]) begin
          s_axis_tvalid <= 1'b0;
          gap_cnt <= gap_cnt + 1;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_q[0].fin;
          s_axis_tdata <= pending_q[0].byte_v;
          void'(pending_q.pop_front());
          void'(hold_q.pop_front());
          gap_cnt <= 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    digest_t exp_d;
    int unsigned wait_n;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", m_axis_tdata[31:0]);
          fail_cnt++;
        end else begin
          exp_d = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_d.word) begin
            $error("digest_word exp %h got %h", exp_d.word, m_axis_tdata[31:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[34:32] !== exp_d.idx) begin
            $error("word_index exp %0d got %0d", exp_d.idx, m_axis_tdata[34:32]);
            fail_cnt++;
          end
          if (m_axis_tlast !== exp_d.last) begin
            $error("last_word exp %0d got %0d", exp_d.last, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
      if (rx_wait == 0) begin
        if (m_axis_tvalid && m_axis_tready) begin
          wait_n = $urandom_range(0, 1) ? $urandom_range(0, 19) : 0;
          rx_wait <= wait_n;
          m_axis_tready <= (wait_n == 0);
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait <= rx_wait - 1;
      end
    end
  end

  initial begin
    fail_cnt = 0;
    feed_done = 0;
    gap_cnt = 0;
    rx_wait = 0;
    idle_cycles = 0;
    fork
      begin
        wait (feed_done && digest_q.size() == 0);
        repeat (300) @(posedge clk_i);
      end
      begin
        forever begin
          @(posedge clk_i);
          if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
          end else begin
            idle_cycles++;
          end
          if (idle_cycles >= WATCHDOG_LIMIT) break;
        end
        fail_cnt++;
      end
    join_any
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
